// File: design/erp_pkg.sv
// ----------------------------------------------------------------------------
// erp_pkg: shared types and constants of the eased rotation profile
// holds register indexes, field widths and the divider request type
// ----------------------------------------------------------------------------
package erp_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF    = 20;
	localparam int unsigned OUTLIER_LIMIT_US_DEF = 200000;

	localparam int unsigned NOMINAL_RESET = 16667;

	// register indexes
	localparam logic [2:0] REG_START    = 3'd0;
	localparam logic [2:0] REG_SWEEP    = 3'd1;
	localparam logic [2:0] REG_DURATION = 3'd2;
	localparam logic [2:0] REG_NOMINAL  = 3'd3;

	// shared divider geometry
	localparam int unsigned DIV_DW = 48;
	localparam int unsigned DIV_VW = 33;

	typedef struct packed {
		logic              go;
		logic [DIV_DW-1:0] dividend;
		logic [DIV_VW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_DW-1:0] quotient;
	} div_rsp_t;

endpackage

// File: design/eased_rotation_profile.sv
// ----------------------------------------------------------------------------
// eased_rotation_profile: sine ease-in/ease-out rotation profile
// smooths frame intervals, advances elapsed time, outputs the eased angle
// ----------------------------------------------------------------------------
// channel   dir  handshake             payload
// s_axis    in   s_tvalid / s_tready   frame_interval_us
// m_axis    out  m_tvalid / m_tready   angle, active, smoothed_interval_us
// cfg       in   cfg_we                cfg_index, cfg_data
//
// one request makes up to three passes of the shared one-bit-a-cycle divider
// (mean, phase, cosine), each of 48 steps, between the sequencer steps; the
// cosine pass is skipped when the folded phase is zero, and the phase and cosine
// passes as well when the end is reached or the duration is zero
// reset clears control state and reseeds the history at once, no clearing pass
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register, so the next request is taken while it is stalled
module eased_rotation_profile #(
	parameter int unsigned HISTORY_DEPTH    = erp_pkg::HISTORY_DEPTH_DEF,
	parameter int unsigned OUTLIER_LIMIT_US = erp_pkg::OUTLIER_LIMIT_US_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] frame_interval_us
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [24:0] angle, [25] active, [43:26] smoothed_interval_us
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// widths that follow from the parameters
	localparam int unsigned LIMW = $clog2(OUTLIER_LIMIT_US + 1);
	localparam int unsigned IW   = (LIMW > 18) ? LIMW : 18;
	localparam int unsigned CW   = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned AW   = $clog2(HISTORY_DEPTH);
	localparam int unsigned SW   = IW + CW;

	// sequencer codes
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_UPD  = 4'd1;
	localparam logic [3:0] ST_MDIV = 4'd2;
	localparam logic [3:0] ST_ELAP = 4'd3;
	localparam logic [3:0] ST_PDIV = 4'd4;
	localparam logic [3:0] ST_SQ   = 4'd5;
	localparam logic [3:0] ST_CDIV = 4'd6;
	localparam logic [3:0] ST_EASE = 4'd7;
	localparam logic [3:0] ST_MUL  = 4'd8;
	localparam logic [3:0] ST_ANG  = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;
	localparam logic [3:0] ST_SQW  = 4'd11;

	logic [3:0] state_q;

	// configuration
	logic signed [23:0] start_q;
	logic signed [23:0] sweep_q;
	logic [31:0]        duration_q;
	logic [17:0]        nominal_q;

	// history
	logic [IW-1:0] hist_mem [HISTORY_DEPTH];
	logic [IW-1:0] rd_q;
	logic          seed0_q;   // entry zero still holds the seed interval
	logic [CW-1:0] count_q;
	logic [AW-1:0] slot_q;
	logic [SW-1:0] sum_q;
	logic [IW-1:0] last_q;
	logic [IW-1:0] intv_q;
	logic [31:0]   elapsed_q;

	// working registers
	logic [IW-1:0]      mean_q;
	logic [15:0]        pp_q;
	logic               neg_q;
	logic [30:0]        sq_q;
	logic [16:0]        hc_q;
	logic [16:0]        ease_q;
	logic signed [41:0] prod_q;
	logic [24:0]        angle_q;
	logic               m_valid_q;
	logic [47:0]        m_data_q;

	// divider request registers
	logic                      div_go_q;
	logic [erp_pkg::DIV_DW-1:0] div_dividend_q;
	logic [erp_pkg::DIV_VW-1:0] div_divisor_q;

	erp_pkg::div_req_t div_req;
	erp_pkg::div_rsp_t div_rsp;

	assign div_req = '{go: div_go_q, dividend: div_dividend_q, divisor: div_divisor_q};

	erp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic          s_acc;
	logic [IW-1:0] t_in;
	logic [IW-1:0] oldest;
	logic [SW-1:0] sum_nxt;
	logic [32:0]   elap_sum;
	logic [16:0]   phase;
	logic          cfg_hit;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign cfg_hit  = cfg_we && (cfg_index <= erp_pkg::REG_NOMINAL);

	// outliers fall back to the last stored interval
	always_comb begin
		if (s_tdata > 24'(OUTLIER_LIMIT_US)) begin
			t_in = last_q;
		end else begin
			t_in = IW'(s_tdata);
		end
	end

	assign oldest   = (slot_q == '0 && seed0_q) ? IW'(nominal_q) : rd_q;
	assign sum_nxt  = (count_q < CW'(HISTORY_DEPTH)) ? sum_q + SW'(intv_q)
	                                                  : sum_q - SW'(oldest) + SW'(intv_q);
	assign elap_sum = {1'b0, elapsed_q} + 33'(mean_q);
	assign phase    = div_rsp.quotient[16:0];

	// history memory, registered read at the write slot
	always_ff @(posedge clk) begin
		rd_q <= hist_mem[slot_q];
		if (state_q == ST_UPD) begin
			hist_mem[slot_q] <= intv_q;
		end
	end

	// divider requests from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			unique case (state_q)
				ST_UPD: begin
					div_go_q <= 1'b1;
				end
				ST_ELAP: begin
					div_go_q <= !(duration_q == '0 || elap_sum[31:0] > duration_q
					              || elap_sum[32]);
				end
				ST_SQ: begin
					div_go_q <= (pp_q != '0);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_UPD: begin
				div_dividend_q <= erp_pkg::DIV_DW'(sum_nxt);
				div_divisor_q  <= erp_pkg::DIV_VW'(count_q < CW'(HISTORY_DEPTH)
				                                   ? count_q + 1'b1 : count_q);
			end
			ST_ELAP: begin
				div_dividend_q <= {(elap_sum[32] ? 32'hFFFF_FFFF : elap_sum[31:0]), 16'h0};
				div_divisor_q  <= {1'b0, duration_q};
			end
			ST_SQ: begin
				// rational cosine: (2^32 - 4p^2) / (2^32 + p^2) in Q1.16
				div_dividend_q <= {32'(33'h1_0000_0000 - {sq_q, 2'b00}), 16'h0};
				div_divisor_q  <= 33'h1_0000_0000 + 33'(sq_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_q    <= '0;
			sweep_q    <= '0;
			duration_q <= '0;
			nominal_q  <= 18'(erp_pkg::NOMINAL_RESET);
			seed0_q    <= 1'b1;
			count_q    <= CW'(1);
			slot_q     <= AW'(1 % HISTORY_DEPTH);
			sum_q      <= SW'(erp_pkg::NOMINAL_RESET);
			last_q     <= IW'(erp_pkg::NOMINAL_RESET);
			elapsed_q  <= '0;
			m_valid_q  <= 1'b0;
			intv_q     <= '0;
			mean_q     <= '0;
			neg_q      <= 1'b0;
			pp_q       <= '0;
			hc_q       <= '0;
			ease_q     <= '0;
			angle_q    <= '0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				elapsed_q <= '0;
				unique case (cfg_index)
					erp_pkg::REG_START:    start_q    <= cfg_data[23:0];
					erp_pkg::REG_SWEEP:    sweep_q    <= cfg_data[23:0];
					erp_pkg::REG_DURATION: duration_q <= cfg_data;
					default: begin
						// reseed the history as on reset
						nominal_q <= cfg_data[17:0];
						seed0_q   <= 1'b1;
						count_q   <= CW'(1);
						slot_q    <= AW'(1 % HISTORY_DEPTH);
						sum_q     <= SW'(cfg_data[17:0]);
						last_q    <= IW'(cfg_data[17:0]);
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						intv_q  <= t_in;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					sum_q  <= sum_nxt;
					last_q <= intv_q;
					if (count_q < CW'(HISTORY_DEPTH)) begin
						count_q <= count_q + 1'b1;
					end
					if (slot_q == '0) begin
						seed0_q <= 1'b0;
					end
					slot_q  <= (slot_q == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
					state_q <= ST_MDIV;
				end
				ST_MDIV: begin
					if (div_rsp.done) begin
						mean_q  <= div_rsp.quotient[IW-1:0];
						state_q <= ST_ELAP;
					end
				end
				ST_ELAP: begin
					// saturating advance of elapsed time
					elapsed_q <= elap_sum[32] ? 32'hFFFF_FFFF : elap_sum[31:0];
					if (duration_q == '0 || elap_sum[31:0] > duration_q || elap_sum[32]) begin
						angle_q <= 25'(start_q) + 25'(sweep_q);
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PDIV;
					end
				end
				ST_PDIV: begin
					if (div_rsp.done) begin
						// fold the second half onto the first
						neg_q   <= phase > 17'd32768;
						pp_q    <= (phase > 17'd32768) ? 16'(17'd65536 - phase) : phase[15:0];
						state_q <= ST_SQW;
					end
				end
				ST_SQW: begin
					// square of the folded phase settles
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_CDIV;
				end
				ST_CDIV: begin
					if (pp_q == '0) begin
						hc_q    <= 17'd65536;
						state_q <= ST_EASE;
					end else if (div_rsp.done) begin
						hc_q    <= div_rsp.quotient[16:0];
						state_q <= ST_EASE;
					end
				end
				ST_EASE: begin
					ease_q  <= neg_q ? 17'((18'd65536 + 18'(hc_q)) >> 1)
					                 : 17'((18'd65536 - 18'(hc_q)) >> 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ANG;
				end
				ST_ANG: begin
					// round half up then add the start angle
					angle_q <= 25'(start_q) + 25'(43'(prod_q) + 43'sd32768 >>> 16);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// multiplier stage: square of the folded phase, sweep times ease, and the output register load
	always_ff @(posedge clk) begin
		sq_q   <= 31'(pp_q) * 31'(pp_q);
		prod_q <= 42'(sweep_q) * 42'($signed({1'b0, ease_q}));
		if (state_q == ST_OUT && (!m_valid_q || m_tready)) begin
			m_data_q <= {4'h0, mean_q[17:0], elapsed_q < duration_q, angle_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// the divider is idle whenever a new request may enter
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_rsp.busy)
		else $error("divider busy while accepting");

	// an accepted request always moves to the history update
	a_acc_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && !cfg_hit) |=> state_q == ST_UPD)
		else $error("accepted request lost");

	// the mean divisor is never zero
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CW'(HISTORY_DEPTH))
		else $error("history count out of range");

	// the output register only loads from the final step
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("result shown outside the output step");

endmodule

// File: design/erp_div.sv
// ----------------------------------------------------------------------------
// erp_div: shared iterative divider
// restoring division, one quotient bit per cycle
// ----------------------------------------------------------------------------
module erp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  erp_pkg::div_req_t req,
	output erp_pkg::div_rsp_t rsp
);

	localparam int unsigned DW = erp_pkg::DIV_DW;
	localparam int unsigned VW = erp_pkg::DIV_VW;
	localparam int unsigned CNTW = $clog2(DW + 1);

	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [VW-1:0]   rem_q;
	logic [DW-1:0]   quo_q;
	logic [VW-1:0]   div_q;
	logic [VW:0]     trial;
	logic            fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				cnt_q  <= CNTW'(DW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so VW bits are enough
			rem_q <= fits ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// File: verif/eased_rotation_profile_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eased_rotation_profile_tb: self-checking bench for the eased rotation profile
// streams frame intervals through the block under random stalls on both
// sides and checks every angle, active flag and smoothed interval against
// a cycle-free model of the history, elapsed time and eased cosine
// ----------------------------------------------------------------------------
module eased_rotation_profile_tb;

	localparam int unsigned DEPTH      = 20;
	localparam int unsigned OUTLIER    = 200000;
	localparam logic [2:0]  REG_UNUSED = 3'd5;   // index with no register behind it
	localparam int unsigned CYCLE_LIMIT = 1500000;
	localparam int unsigned HOLD_CYCLES = 2000;

	typedef struct packed {
		logic signed [24:0] angle;
		logic               active;
		logic [17:0]        smoothed;
	} pose_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [23:0] frame_interval_us
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // [24:0] angle, [25] active, [43:26] smoothed_interval_us
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	eased_rotation_profile dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the configuration registers
	logic signed [23:0] start_q, sweep_q;
	logic [31:0]        duration_q;
	logic [17:0]        nominal_q;

	// shadow of the smoothing and timing state
	logic [17:0] hist[DEPTH];
	int unsigned fill_cnt, slot;
	longint unsigned hist_sum;
	logic [17:0] last_iv;
	logic [31:0] elapsed_q;

	logic [23:0] interval_q[$];   // frame intervals waiting to be offered
	pose_t       pose_q[$];       // predicted poses, oldest first

	int unsigned errors, requests_sent, poses_seen, outliers_sent, cycles;
	bit quiet;                    // no idling on either side
	bit hold;                     // receiver held off
	bit s_fired;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
		errors++;
		$display("pose %0d: %s expected %0d got %0d", poses_seen, what, exp_v, got_v);
	endtask

	// history reseed, as on reset or a write of the nominal interval
	function automatic void reseed();
		foreach (hist[i]) hist[i] = '0;
		hist[0]  = nominal_q;
		fill_cnt = 1;
		slot     = 1;
		hist_sum = nominal_q;
		last_iv  = nominal_q;
	endfunction

	// rational cosine approximation of pi*p/65536 on the first half, Q1.16
	function automatic longint half_cos(input longint unsigned p);
		longint unsigned num, den;
		num = 64'd4294967296 - 4 * p * p;
		den = 64'd4294967296 + p * p;
		return longint'((num << 16) / den);
	endfunction

	function automatic pose_t advance_pose(input logic [23:0] iv_in);
		pose_t r;
		logic [31:0] iv, mean;
		longint unsigned nxt, p;
		longint c, ease, prod;
		logic signed [31:0] ang;
		iv = iv_in;
		if (iv > OUTLIER) iv = last_iv;   // outlier replaced by the last interval
		if (fill_cnt < DEPTH) fill_cnt++;
		else hist_sum -= hist[slot];      // full history: drop the oldest
		hist[slot] = iv[17:0];
		hist_sum += iv;
		last_iv = iv[17:0];
		slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
		mean = 32'(hist_sum / fill_cnt);
		nxt = longint'(elapsed_q) + mean;
		elapsed_q = (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
		if (duration_q == 0 || elapsed_q > duration_q) begin
			ang = 32'(start_q) + 32'(sweep_q);
		end else begin
			p = (longint'(elapsed_q) << 16) / duration_q;
			c = (p <= 32768) ? half_cos(p) : -half_cos(65536 - p);
			ease = (65536 - c) / 2;
			prod = longint'(sweep_q) * ease;
			ang = 32'(start_q) + 32'((prod + 32768) >>> 16);
		end
		r.angle    = ang[24:0];
		r.active   = elapsed_q < duration_q;
		r.smoothed = mean[17:0];
		return r;
	endfunction

	// register write while idle, shadow updated alongside
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			erp_pkg::REG_START:    start_q = val[23:0];
			erp_pkg::REG_SWEEP:    sweep_q = val[23:0];
			erp_pkg::REG_DURATION: duration_q = val;
			erp_pkg::REG_NOMINAL: begin
				nominal_q = val[17:0];
				reseed();
			end
			default: ;
		endcase
		if (idx <= erp_pkg::REG_NOMINAL) elapsed_q = '0;   // any real write restarts the sweep
	endtask

	// wait until every request has come back, then let the sequencer settle
	task automatic drain();
		while (interval_q.size() != 0 || s_tvalid || pose_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// append one interval to the pending list
	task automatic queue_interval(input logic [23:0] iv);
		interval_q.insert(interval_q.size(), iv);
	endtask

	function automatic logic [23:0] rand_interval();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 55) return 24'($urandom_range(40000, 1000));
		if (k < 75) return 24'($urandom_range(OUTLIER));
		if (k < 82) return (k & 1) ? 24'(OUTLIER) : 24'(OUTLIER + 1);
		if (k < 90) return 24'($urandom_range(60));
		return 24'($urandom());                    // mostly outliers, all bits toggle
	endfunction

	// driver: intervals offered at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_fired) begin
			if (interval_q.size() != 0 && (quiet || $urandom_range(99) >= 9)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= interval_q[0];
				interval_q.delete(0);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver readiness, with the long hold-off taking priority
	always @(negedge clk) begin
		if (hold) m_tready <= 1'b0;
		else m_tready <= quiet || $urandom_range(99) >= 9;
	end

	// monitor: requests predicted and poses checked at the rising edge
	always @(posedge clk) begin
		pose_t got, exp_p;
		s_fired = 1'b0;
		if (arst_n) begin
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d poses outstanding", cycles,
					pose_q.size());
				$display("eased_rotation_profile: mismatch");
				$finish;
			end
			if (s_tvalid && s_tready) begin
				s_fired = 1'b1;
				requests_sent++;
				if (s_tdata > OUTLIER) outliers_sent++;
				exp_p = advance_pose(s_tdata);
				pose_q.insert(pose_q.size(), exp_p);
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[24:0], m_tdata[25], m_tdata[43:26]};
				if (pose_q.size() == 0) begin
					report_mismatch("unexpected pose, angle", 0, got.angle);
				end else begin
					exp_p = pose_q[0];
					pose_q.delete(0);
					if (got.angle !== exp_p.angle)
						report_mismatch("angle", exp_p.angle, got.angle);
					if (got.active !== exp_p.active)
						report_mismatch("active", exp_p.active, got.active);
					if (got.smoothed !== exp_p.smoothed)
						report_mismatch("smoothed interval", exp_p.smoothed, got.smoothed);
				end
				poses_seen++;
			end
		end
	end

	// long receiver hold-off once traffic is flowing, sender keeps offering
	initial begin
		hold = 1'b0;
		wait (requests_sent >= 300);
		@(negedge clk);
		hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		@(negedge clk);
		hold = 1'b0;
	end

	initial begin
		logic [31:0] dur;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		start_q = '0;
		sweep_q = '0;
		duration_q = '0;
		nominal_q = 18'(erp_pkg::NOMINAL_RESET);
		elapsed_q = '0;
		reseed();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, field extremes, outliers, history filling up
		interval_q = {24'd0, 24'(OUTLIER), 24'(OUTLIER + 1), 24'hFFFFFF, 24'd1,
			24'h800000, 24'd16667, 24'd33333, 24'h7FFFFF, 24'd0};
		repeat (14) queue_interval(24'($urandom_range(OUTLIER)));
		drain();

		// extremes of the angle and a short sweep that runs past its end
		write_reg(erp_pkg::REG_START, 32'hFF80_0000);
		write_reg(erp_pkg::REG_SWEEP, 32'h007F_FFFF);
		write_reg(erp_pkg::REG_DURATION, 32'd400000);
		write_reg(erp_pkg::REG_NOMINAL, 32'd200000);
		repeat (25) queue_interval(rand_interval());
		drain();

		// nominal above the outlier limit, unused index, longest duration
		write_reg(erp_pkg::REG_START, 32'h007F_FFFF);
		write_reg(erp_pkg::REG_SWEEP, 32'hFF80_0000);
		write_reg(erp_pkg::REG_NOMINAL, 32'hFFFF_FFFF);
		write_reg(REG_UNUSED, $urandom());
		write_reg(erp_pkg::REG_DURATION, 32'hFFFF_FFFF);
		repeat (25) queue_interval(24'hFFFFFF);
		drain();

		// random settings, one phase run without any idling
		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(4))
				0: dur = '0;
				1: dur = $urandom_range(1000000, 1000);
				2: dur = $urandom_range(20000000, 1000000);
				3: dur = 32'hFFFF_FFFF;
				default: dur = $urandom();
			endcase
			write_reg(erp_pkg::REG_START, $urandom());
			write_reg(erp_pkg::REG_SWEEP, $urandom());
			if ($urandom_range(1)) write_reg(erp_pkg::REG_NOMINAL, $urandom_range(OUTLIER));
			write_reg(erp_pkg::REG_DURATION, dur);
			quiet = (ph == 4);
			repeat (135) queue_interval(rand_interval());
			drain();
			quiet = 1'b0;
		end

		$display("%0d frame intervals sent, %0d of them outliers, %0d poses checked",
			requests_sent, outliers_sent, poses_seen);
		$display("covered angle and nominal extremes, zero and longest durations, "
			, "runs past the end and a %0d-cycle output stall", HOLD_CYCLES);
		if (errors == 0) begin
			$display("eased_rotation_profile: match");
		end else begin
			$display("eased_rotation_profile: mismatch");
		end
		$finish;
	end

endmodule

// File: files.f
design/erp_pkg.sv
design/erp_div.sv
design/eased_rotation_profile.sv
verif/eased_rotation_profile_tb.sv
